>>> design/srtl_pkg.sv
// shared types and constants for the shuffled remap table lookup
// no dependencies
`timescale 1ns / 1ps
package srtl_pkg;
   localparam int TABLE_DEPTH_DEF = 256;
   localparam logic [1:0] KIND_LOAD = 2'd0;
   localparam logic [1:0] KIND_SHUFFLE = 2'd1;
   localparam logic [1:0] KIND_LOOKUP = 2'd2;
   localparam logic [1:0] KIND_NONE = 2'd3;
   localparam logic [1:0] REG_A_COUNT = 2'd0;
   localparam logic [1:0] REG_B_COUNT = 2'd1;
   localparam logic [1:0] REG_CLASS_MASK = 2'd2;
   localparam logic [1:0] REG_CARRY_MASK = 2'd3;

   typedef enum logic [3:0] {
      ST_IDLE, ST_LOAD, ST_SH_DIV, ST_SH_RD, ST_SH_WAIT, ST_SH_WR1, ST_SH_WR2,
      ST_LK_INIT, ST_LK_PROBE, ST_LK_WAIT, ST_LK_CMP, ST_RESP
   } state_type;

   typedef struct packed {
      logic capture;
      logic do_load;
      logic div_start;
      logic sh_read;
      logic sh_wr_cur;
      logic sh_wr_j;
      logic lk_init;
      logic lk_cmp;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic kind_load;
      logic kind_shuffle;
      logic kind_lookup;
      logic sh_empty;
      logic div_busy;
      logic lk_done;
   } status_type;
endpackage

>>> design/shuffled_remap_table_lookup.sv
// top level of the shuffled remap table lookup
// accept to result: load writes one entry, shuffle runs the modulo then swaps two values,
// lookup makes up to 9 probes for 256 entries; one word in flight
// the result register frees the sequencer as soon as the word is taken
// sync active-high reset clears counts, cursors, control; masks 128/16; tables undefined
`timescale 1ns / 1ps
module shuffled_remap_table_lookup #(
   parameter int TABLE_DEPTH = srtl_pkg::TABLE_DEPTH_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // table_sel, entry_index, entry_key, entry_value, random_word, query_sound
   input  logic [127:0] req_tdata,
   // kind
   input  logic [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // mapped_sound, hit, shuffle_done
   output logic [39:0]  rsp_tdata,
   // unused, zero
   output logic         rsp_tuser,
   input  logic         csr_we,
   input  logic [1:0]   csr_index,
   input  logic [31:0]  csr_wdata
);
   srtl_pkg::cmd_type cmd;
   srtl_pkg::status_type st;
   logic out_full;

   // sequencer
   srtl_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
      .out_full(out_full), .st(st), .cmd(cmd)
   );

   // tables and arithmetic
   srtl_data #(.TABLE_DEPTH(TABLE_DEPTH)) u_data (
      .clock(clock), .reset(reset), .req_tdata(req_tdata), .req_tuser(req_tuser),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .cmd(cmd), .st(st), .out_full(out_full), .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   // a word is never accepted while the sequencer is busy
   a_one_word: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> !req_tready) else $error("accepted while busy");
   // modulo is never started back to back
   a_div: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |=> !cmd.div_start) else $error("double modulo start");
   // result loaded only when it can be held
   a_out: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> !out_full) else $error("result overwrite");
endmodule

>>> design/srtl_ctrl.sv
// sequencer for load, shuffle and lookup words
// depends on srtl_pkg
`timescale 1ns / 1ps
module srtl_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic                 out_full,
   input  srtl_pkg::status_type st,
   output srtl_pkg::cmd_type    cmd
);
   srtl_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= srtl_pkg::ST_IDLE;
      else state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         srtl_pkg::ST_IDLE: if (req_tvalid) state_in = srtl_pkg::ST_LOAD;
         srtl_pkg::ST_LOAD: begin
            priority if (st.kind_shuffle) begin
               state_in = st.sh_empty ? srtl_pkg::ST_RESP : srtl_pkg::ST_SH_DIV;
            end else if (st.kind_lookup) state_in = srtl_pkg::ST_LK_INIT;
            else state_in = srtl_pkg::ST_RESP;
         end
         srtl_pkg::ST_SH_DIV: if (!st.div_busy) state_in = srtl_pkg::ST_SH_RD;
         srtl_pkg::ST_SH_RD: state_in = srtl_pkg::ST_SH_WAIT;
         srtl_pkg::ST_SH_WAIT: state_in = srtl_pkg::ST_SH_WR1;
         srtl_pkg::ST_SH_WR1: state_in = srtl_pkg::ST_SH_WR2;
         srtl_pkg::ST_SH_WR2: state_in = srtl_pkg::ST_RESP;
         srtl_pkg::ST_LK_INIT: state_in = srtl_pkg::ST_LK_PROBE;
         srtl_pkg::ST_LK_PROBE: begin
            state_in = st.lk_done ? srtl_pkg::ST_RESP : srtl_pkg::ST_LK_WAIT;
         end
         srtl_pkg::ST_LK_WAIT: state_in = srtl_pkg::ST_LK_CMP;
         srtl_pkg::ST_LK_CMP: state_in = srtl_pkg::ST_LK_PROBE;
         srtl_pkg::ST_RESP: if (!out_full) state_in = srtl_pkg::ST_IDLE;
         default: state_in = srtl_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         srtl_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            cmd.capture = req_tvalid;
         end
         srtl_pkg::ST_LOAD: begin
            cmd.do_load = st.kind_load;
            cmd.div_start = st.kind_shuffle & ~st.sh_empty;
         end
         srtl_pkg::ST_SH_RD: cmd.sh_read = 1'b1;
         srtl_pkg::ST_SH_WR1: cmd.sh_wr_cur = 1'b1;
         srtl_pkg::ST_SH_WR2: cmd.sh_wr_j = 1'b1;
         srtl_pkg::ST_LK_INIT: cmd.lk_init = 1'b1;
         srtl_pkg::ST_LK_CMP: cmd.lk_cmp = 1'b1;
         srtl_pkg::ST_RESP: cmd.out_load = ~out_full;
         default: cmd = '0;
      endcase
   end
endmodule

>>> design/srtl_data.sv
// tables, cursors, modulo unit, search registers and result register
// depends on srtl_pkg
`timescale 1ns / 1ps
module srtl_data #(
   parameter int TABLE_DEPTH = srtl_pkg::TABLE_DEPTH_DEF,
   localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
   localparam int CW = $clog2(TABLE_DEPTH + 1)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [127:0]         req_tdata,
   input  logic [1:0]           req_tuser,
   input  logic                 csr_we,
   input  logic [1:0]           csr_index,
   input  logic [31:0]          csr_wdata,
   input  srtl_pkg::cmd_type    cmd,
   output srtl_pkg::status_type st,
   output logic                 out_full,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [39:0]          rsp_tdata,
   output logic                 rsp_tuser
);
   // captured word
   logic [1:0] kind_ff;
   logic tsel_ff;
   logic [7:0] idx_ff;
   logic [31:0] key_ff, val_ff, q_ff;
   logic [15:0] rnd_ff;
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff <= req_tuser;
         tsel_ff <= req_tdata[0];
         idx_ff <= req_tdata[8:1];
         key_ff <= req_tdata[40:9];
         val_ff <= req_tdata[72:41];
         rnd_ff <= req_tdata[88:73];
         q_ff <= req_tdata[120:89];
      end
   end

   // configuration
   logic [8:0] cnt_ff [2];
   logic [31:0] cmask_ff, kmask_ff;
   logic [IW-1:0] cur_ff [2];
   logic [CW-1:0] eff [2];
   always_comb begin
      for (int t = 0; t < 2; t++) begin
         if ({23'd0, cnt_ff[t]} > TABLE_DEPTH) eff[t] = CW'(TABLE_DEPTH);
         else eff[t] = CW'(cnt_ff[t]);
      end
   end

   // cursor reload value for a count write: saturated count minus one
   logic [CW-1:0] csr_sat;
   logic [IW-1:0] csr_cur;
   assign csr_sat = ({23'd0, csr_wdata[8:0]} > TABLE_DEPTH) ? CW'(TABLE_DEPTH) :
                    CW'(csr_wdata[8:0]);
   assign csr_cur = (csr_sat == '0) ? '0 : IW'(csr_sat - 1'b1);

   // memories
   logic [31:0] keys_mem [2**(IW+1)];
   logic [31:0] vals_mem [2**(IW+1)];
   logic [31:0] krd_ff, vrd_ff;
   logic [IW:0] raddr, waddr;
   logic [31:0] wval;
   logic vwe;

   // shuffle
   logic [CW-1:0] c_sh;
   logic [IW-1:0] cur_sh;
   logic [IW-1:0] j_ff;
   logic [31:0] vcur_ff;
   assign c_sh = eff[tsel_ff];
   assign cur_sh = ({1'b0, cur_ff[tsel_ff]} >= (IW+1)'(c_sh)) ?
                   IW'(c_sh - 1'b1) : cur_ff[tsel_ff];

   // restoring modulo, one quotient bit per cycle
   logic [16:0] rem_ff;
   logic [15:0] dvd_ff;
   logic [4:0] dcnt_ff;
   logic busy_ff;
   logic [16:0] trial;
   assign trial = {rem_ff[15:0], dvd_ff[15]};
   always_ff @(posedge clock) begin
      if (reset) busy_ff <= 1'b0;
      else if (cmd.div_start) begin
         busy_ff <= 1'b1;
         rem_ff <= '0;
         dvd_ff <= rnd_ff;
         dcnt_ff <= 5'd16;
      end else if (busy_ff) begin
         dvd_ff <= {dvd_ff[14:0], 1'b0};
         if (trial >= 17'(cur_sh) + 17'd1) rem_ff <= trial - (17'(cur_sh) + 17'd1);
         else rem_ff <= trial;
         dcnt_ff <= dcnt_ff - 5'd1;
         if (dcnt_ff == 5'd1) busy_ff <= 1'b0;
      end
   end
   always_ff @(posedge clock) if (cmd.sh_read) j_ff <= IW'(rem_ff);

   // search
   logic signed [IW+1:0] lo_ff, hi_ff;
   logic signed [IW+1:0] mid;
   logic s_ff, hit_ff;
   assign mid = lo_ff + ((hi_ff - lo_ff) >>> 1);

   // during a lookup the probe address holds until the compare moves lo or hi
   always_comb begin
      raddr = '0;
      if (cmd.sh_read) raddr = {tsel_ff, cur_sh};
      else if (st.kind_lookup) raddr = {s_ff, IW'(mid)};
      else raddr = {tsel_ff, j_ff};
      vwe = 1'b0;
      waddr = {tsel_ff, IW'(idx_ff)};
      wval = val_ff;
      if (cmd.do_load && ({24'd0, idx_ff} < TABLE_DEPTH)) vwe = 1'b1;
      if (cmd.sh_wr_cur) begin
         vwe = 1'b1; waddr = {tsel_ff, cur_sh}; wval = vrd_ff;
      end
      if (cmd.sh_wr_j) begin
         vwe = 1'b1; waddr = {tsel_ff, j_ff}; wval = vcur_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.do_load && ({24'd0, idx_ff} < TABLE_DEPTH)) keys_mem[waddr] <= key_ff;
      if (vwe) vals_mem[waddr] <= wval;
      krd_ff <= keys_mem[raddr];
      vrd_ff <= vals_mem[raddr];
   end

   // read of j comes in the cycle after the read of cur: hold cur value
   always_ff @(posedge clock) if (cmd.sh_read) vcur_ff <= vals_mem[{tsel_ff, cur_sh}];

   logic lt;
   assign lt = $signed(krd_ff) < $signed(q_ff);
   always_ff @(posedge clock) begin
      if (cmd.lk_init) begin
         s_ff <= ~|(q_ff & cmask_ff);
         lo_ff <= '0;
         hi_ff <= (IW+2)'(eff[~|(q_ff & cmask_ff) ? 1 : 0]) - 1'b1;
         hit_ff <= 1'b0;
      end else if (cmd.lk_cmp) begin
         if (krd_ff == q_ff) begin
            hit_ff <= 1'b1;
            lo_ff <= hi_ff + 1'b1;
         end else if (lt) lo_ff <= mid + 1'b1;
         else hi_ff <= mid - 1'b1;
      end
   end
   logic [31:0] hval_ff;
   always_ff @(posedge clock) if (cmd.lk_cmp && krd_ff == q_ff) hval_ff <= vrd_ff;

   assign st.kind_load = (kind_ff == srtl_pkg::KIND_LOAD);
   assign st.kind_shuffle = (kind_ff == srtl_pkg::KIND_SHUFFLE);
   assign st.kind_lookup = (kind_ff == srtl_pkg::KIND_LOOKUP);
   assign st.sh_empty = (c_sh == '0);
   assign st.div_busy = busy_ff | cmd.div_start;
   assign st.lk_done = (lo_ff > hi_ff);

   // config and cursors
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff[0] <= '0; cnt_ff[1] <= '0;
         cmask_ff <= 32'd128; kmask_ff <= 32'd16;
         cur_ff[0] <= '0; cur_ff[1] <= '0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               srtl_pkg::REG_A_COUNT: begin
                  cnt_ff[0] <= csr_wdata[8:0];
                  cur_ff[0] <= csr_cur;
               end
               srtl_pkg::REG_B_COUNT: begin
                  cnt_ff[1] <= csr_wdata[8:0];
                  cur_ff[1] <= csr_cur;
               end
               srtl_pkg::REG_CLASS_MASK: cmask_ff <= csr_wdata;
               srtl_pkg::REG_CARRY_MASK: kmask_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (cmd.out_load && st.kind_shuffle) begin
            if (c_sh == '0) cur_ff[tsel_ff] <= '0;
            else if (cur_sh == '0) cur_ff[tsel_ff] <= IW'(c_sh - 1'b1);
            else cur_ff[tsel_ff] <= cur_sh - 1'b1;
         end
      end
   end

   // result register
   logic vld_ff;
   logic [33:0] res_ff, res_in;
   always_comb begin
      res_in = '0;
      if (st.kind_lookup) begin
         res_in[31:0] = hit_ff ? ((hval_ff & ~kmask_ff) | (q_ff & kmask_ff)) : q_ff;
         res_in[32] = hit_ff;
      end
      if (st.kind_shuffle) res_in[33] = (c_sh == '0) || (cur_sh == '0);
   end
   always_ff @(posedge clock) begin
      if (reset) vld_ff <= 1'b0;
      else if (cmd.out_load) vld_ff <= 1'b1;
      else if (rsp_tready) vld_ff <= 1'b0;
   end
   always_ff @(posedge clock) begin
      if (cmd.out_load) res_ff <= res_in;
   end
   assign out_full = vld_ff & ~rsp_tready;
   assign rsp_tvalid = vld_ff;
   assign rsp_tdata = {6'd0, res_ff};
   assign rsp_tuser = 1'b0;
endmodule

>>> sim/remap_lookup_checker.sv
// checker for the shuffled remap table lookup: watches the word channels and
// register writes, predicts each result and compares; depends on srtl_pkg
`timescale 1ns / 1ps
module remap_lookup_checker (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [127:0] req_tdata,
   input  logic [1:0]   req_tuser,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [39:0]  rsp_tdata,
   input  logic         csr_we,
   input  logic [1:0]   csr_index,
   input  logic [31:0]  csr_wdata,
   output int           fail_count,
   output int           pending
);
   localparam int DEPTH = srtl_pkg::TABLE_DEPTH_DEF;

   typedef struct packed {
      logic [31:0] mapped;
      logic        hit;
      logic        done;
   } remap_result_type;

   logic [31:0]      key_mem [2][DEPTH];
   logic [31:0]      val_mem [2][DEPTH];
   logic [7:0]       cursor [2];
   logic [8:0]       count_reg [2];
   logic [31:0]      class_mask_reg;
   logic [31:0]      carry_mask_reg;
   remap_result_type remap_queue [$];

   function automatic int eff_count(input int t);
      return (count_reg[t] > DEPTH) ? DEPTH : int'(count_reg[t]);
   endfunction

   function automatic void reload_cursor(input int t);
      int c;
      c = eff_count(t);
      cursor[t] = (c == 0) ? 8'd0 : 8'(c - 1);
   endfunction

   // one word of stimulus through the table model
   function automatic remap_result_type compute_remap(input logic [1:0] kind,
                                                      input logic [127:0] d);
      remap_result_type r;
      int t, c, cur, j, lo, hi, mid;
      logic [31:0] q, k, tmp;
      r = '0;
      t = int'(d[0]);
      q = d[120:89];
      case (kind)
         srtl_pkg::KIND_LOAD: begin
            key_mem[t][d[8:1]] = d[40:9];
            val_mem[t][d[8:1]] = d[72:41];
         end
         srtl_pkg::KIND_SHUFFLE: begin
            c = eff_count(t);
            if (c == 0) begin
               cursor[t] = 8'd0;
               r.done = 1'b1;
            end else begin
               cur = int'(cursor[t]);
               if (cur >= c) cur = c - 1;
               j = int'(d[88:73]) % (cur + 1);
               tmp = val_mem[t][cur];
               val_mem[t][cur] = val_mem[t][j];
               val_mem[t][j] = tmp;
               if (cur == 0) begin
                  cursor[t] = 8'(c - 1);
                  r.done = 1'b1;
               end else begin
                  cursor[t] = 8'(cur - 1);
               end
            end
         end
         srtl_pkg::KIND_LOOKUP: begin
            // class bit present picks table zero
            t = ((q & class_mask_reg) != 0) ? 0 : 1;
            lo = 0;
            hi = eff_count(t) - 1;
            r.mapped = q;
            while (lo <= hi) begin
               mid = lo + (hi - lo) / 2;
               k = key_mem[t][mid];
               if (k == q) begin
                  r.mapped = (val_mem[t][mid] & ~carry_mask_reg) | (q & carry_mask_reg);
                  r.hit = 1'b1;
                  break;
               end
               if ($signed(k) < $signed(q)) lo = mid + 1;
               else hi = mid - 1;
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (fail_count < 40)
         $display("%0t: %s got %h want %h", $realtime, what, got, want);
      fail_count++;
   endtask

   always @(posedge clock) begin
      remap_result_type e;
      if (reset) begin
         count_reg[0] = '0;
         count_reg[1] = '0;
         class_mask_reg = 32'd128;
         carry_mask_reg = 32'd16;
         reload_cursor(0);
         reload_cursor(1);
         remap_queue.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               srtl_pkg::REG_A_COUNT: begin
                  count_reg[0] = csr_wdata[8:0];
                  reload_cursor(0);
               end
               srtl_pkg::REG_B_COUNT: begin
                  count_reg[1] = csr_wdata[8:0];
                  reload_cursor(1);
               end
               srtl_pkg::REG_CLASS_MASK: class_mask_reg = csr_wdata;
               srtl_pkg::REG_CARRY_MASK: carry_mask_reg = csr_wdata;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            remap_queue.push_back(compute_remap(req_tuser, req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            if (remap_queue.size() == 0) begin
               report_mismatch("unexpected word", rsp_tdata[31:0], 32'd0);
            end else begin
               e = remap_queue.pop_front();
               if (rsp_tdata[31:0] !== e.mapped)
                  report_mismatch("mapped_sound", rsp_tdata[31:0], e.mapped);
               if (rsp_tdata[32] !== e.hit)
                  report_mismatch("hit", 32'(rsp_tdata[32]), 32'(e.hit));
               if (rsp_tdata[33] !== e.done)
                  report_mismatch("shuffle_done", 32'(rsp_tdata[33]), 32'(e.done));
            end
         end
      end
      pending = remap_queue.size();
   end
endmodule

>>> sim/shuffled_remap_table_lookup_tb.sv
// testbench top for the shuffled remap table lookup: makes stimulus and gives
// the verdict; depends on srtl_pkg, the block and remap_lookup_checker
`timescale 1ns / 1ps
module shuffled_remap_table_lookup_tb;
   localparam int WATCHDOG_LIMIT = 3000;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   // table_sel, entry_index, entry_key, entry_value, random_word, query_sound
   logic [127:0] req_tdata = '0;
   // kind
   logic [1:0]   req_tuser = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   // mapped_sound, hit, shuffle_done
   logic [39:0]  rsp_tdata;
   logic         rsp_tuser;
   logic         csr_we = 1'b0;
   logic [1:0]   csr_index = '0;
   logic [31:0]  csr_wdata = '0;

   int fail_count, pending;
   int send_idle_pct = 0;        // chance the sender skips a cycle
   int stall_pct = 0;            // chance the receiver holds off a cycle
   int hold_req = 0, hold_seen = 0, hold_left = 0;
   int quiet_cycles = 0;

   // sorted keys as loaded, kept to aim queries at real entries
   logic [31:0] loaded_key [2][256];

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   shuffled_remap_table_lookup uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   remap_lookup_checker checker_i (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .fail_count(fail_count), .pending(pending)
   );

   // receiver: random stalls, plus a long hold-off on request
   always @(posedge clock) begin
      if (hold_req != hold_seen) begin
         hold_seen = hold_req;
         hold_left = 300;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // watchdog on cycles with no word moving on either side
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // offer one word with the fields given, after random sender idles
   task automatic send_word(input logic [1:0] kind, input logic tsel, input logic [7:0] idx,
                            input logic [31:0] key, input logic [31:0] val,
                            input logic [15:0] rnd, input logic [31:0] q);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= {7'd0, q, rnd, val, key, idx, tsel};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic send_kind(input logic [1:0] kind, input logic tsel, input logic [31:0] q);
      send_word(kind, tsel, 8'($urandom), $urandom, $urandom, 16'($urandom), q);
   endtask

   // wait until every accepted word has its result
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      wait (pending == 0);
      @(posedge clock);
   endtask

   // register writes only once the block has drained
   task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
      drain();
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // query: mostly a loaded key, with carry and class bits left as they fall
   function automatic logic [31:0] pick_query();
      if ($urandom_range(99) < 70)
         return loaded_key[$urandom_range(1)][$urandom_range(255)];
      return $urandom;
   endfunction

   task automatic random_word_item();
      int r;
      logic [7:0] idx;
      r = $urandom_range(99);
      idx = 8'($urandom);
      if (r < 45) begin
         send_kind(srtl_pkg::KIND_LOOKUP, 1'($urandom), pick_query());
      end else if (r < 75) begin
         send_kind(srtl_pkg::KIND_SHUFFLE, 1'($urandom), $urandom);
      end else if (r < 90) begin
         // reload: mostly same key with a fresh value, sometimes any key
         if ($urandom_range(9) == 0) begin
            send_word(srtl_pkg::KIND_LOAD, 1'b0, idx, $urandom, $urandom, 16'($urandom),
                      $urandom);
         end else begin
            r = $urandom_range(1);
            send_word(srtl_pkg::KIND_LOAD, 1'(r), idx, loaded_key[r][idx], $urandom,
                      16'($urandom), $urandom);
         end
      end else begin
         send_kind(srtl_pkg::KIND_NONE, 1'($urandom), $urandom);
      end
   endtask

   initial begin
      int c0, c1;
      logic [31:0] cm, km;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty tables: shuffles finish a pass at once, lookups miss
      send_kind(srtl_pkg::KIND_SHUFFLE, 1'b0, $urandom);
      send_kind(srtl_pkg::KIND_SHUFFLE, 1'b1, $urandom);
      send_kind(srtl_pkg::KIND_LOOKUP, 1'b0, 32'h0000_0080);

      // fill both tables with ascending signed keys spanning the full range
      for (int t = 0; t < 2; t++)
         for (int i = 0; i < 256; i++) begin
            loaded_key[t][i] = {8'(i), 24'($urandom)} ^ 32'h8000_0000;
            if (i == 0) loaded_key[t][i] = 32'h8000_0000;
            if (i == 255) loaded_key[t][i] = 32'h7fff_ffff;
            send_word(srtl_pkg::KIND_LOAD, 1'(t), 8'(i), loaded_key[t][i], $urandom,
                      16'($urandom), $urandom);
         end

      // directed: full tables, key extremes, misses, unused kind, saturation
      write_reg(srtl_pkg::REG_A_COUNT, 32'd256);
      write_reg(srtl_pkg::REG_B_COUNT, 32'd511);
      write_reg(srtl_pkg::REG_CLASS_MASK, 32'h0000_0080);
      write_reg(srtl_pkg::REG_CARRY_MASK, 32'hffff_ffff);
      send_kind(srtl_pkg::KIND_LOOKUP, 1'b0, 32'h8000_0000);
      send_kind(srtl_pkg::KIND_LOOKUP, 1'b0, 32'h7fff_ffff);
      send_kind(srtl_pkg::KIND_LOOKUP, 1'b0, loaded_key[0][128] | 32'h80);
      send_kind(srtl_pkg::KIND_LOOKUP, 1'b0, loaded_key[1][37]);
      send_kind(srtl_pkg::KIND_LOOKUP, 1'b0, loaded_key[1][37] + 1);
      send_kind(srtl_pkg::KIND_NONE, 1'b1, $urandom);
      send_word(srtl_pkg::KIND_SHUFFLE, 1'b0, 8'd0, '0, '0, 16'hffff, '0);
      send_word(srtl_pkg::KIND_SHUFFLE, 1'b1, 8'd0, '0, '0, 16'h0000, '0);
      // one entry: every step is a self-swap that ends the pass
      write_reg(srtl_pkg::REG_A_COUNT, 32'd1);
      write_reg(srtl_pkg::REG_CARRY_MASK, 32'd0);
      send_kind(srtl_pkg::KIND_SHUFFLE, 1'b0, $urandom);
      send_kind(srtl_pkg::KIND_SHUFFLE, 1'b0, $urandom);
      send_kind(srtl_pkg::KIND_LOOKUP, 1'b0, 32'h8000_0080);
      // two entries: pass ends every second step
      write_reg(srtl_pkg::REG_A_COUNT, 32'd2);
      for (int i = 0; i < 3; i++) send_kind(srtl_pkg::KIND_SHUFFLE, 1'b0, $urandom);

      // random phases, each under its own register setting and one of four idle patterns
      for (int p = 0; p < 8; p++) begin
         case (p % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 87; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 87; end
            default: begin send_idle_pct = 22; stall_pct = 22; end
         endcase
         case (p)
            0: begin c0 = 256; c1 = 256; cm = 32'h80;        km = 32'h10;        end
            1: begin c0 = 0;   c1 = 511; cm = 32'hffff_ffff; km = 32'hffff_ffff; end
            2: begin c0 = 3;   c1 = 1;   cm = 32'd0;         km = 32'd0;         end
            default: begin
               c0 = $urandom_range(2, 256);
               c1 = $urandom_range(2, 256);
               cm = $urandom;
               km = $urandom;
            end
         endcase
         write_reg(srtl_pkg::REG_A_COUNT, 32'(c0));
         write_reg(srtl_pkg::REG_B_COUNT, 32'(c1));
         write_reg(srtl_pkg::REG_CLASS_MASK, cm);
         write_reg(srtl_pkg::REG_CARRY_MASK, km);
         for (int i = 0; i < 70; i++) begin
            random_word_item();
            // long receiver hold-off while words keep coming
            if (p == 4 && i == 20) hold_req++;
            // let the block drain completely once
            if (p == 5 && i == 60) drain();
         end
      end

      drain();
      repeat (60) @(posedge clock);
      if (fail_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule

>>> sim.f
design/srtl_pkg.sv
design/srtl_ctrl.sv
design/srtl_data.sv
design/shuffled_remap_table_lookup.sv
sim/remap_lookup_checker.sv
sim/shuffled_remap_table_lookup_tb.sv
